// ===== src/plap_pkg.sv =====
// Shared types and constants for the polyline arc-length interpolator.
package plap_pkg;

  localparam int unsigned MaxPointsDef = 64;
  localparam int unsigned CoordW = 16;
  localparam int unsigned LenW = 25;
  localparam int unsigned PosW = 24;
  localparam logic [LenW-1:0] LenMax = {LenW{1'b1}};
  localparam int unsigned RootSteps = 25;
  localparam int unsigned DivSteps = 50;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_SHORT = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APP_RD,
    S_APP_SQ,
    S_APP_INIT,
    S_APP_ROOT,
    S_APP_WR,
    S_QRY_END,
    S_QRY_TAIL,
    S_QRY_CHK,
    S_QRY_MUL,
    S_QRY_DIV,
    S_QRY_FIN,
    S_OUT
  } state_e;

  // One stored point with its cumulative bound.
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [LenW-1:0]          bound;
  } entry_t;

endpackage

// ===== src/plap_if.sv =====
// Request and response channel interfaces of the interpolator.
interface plap_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            op;
  logic signed [plap_pkg::CoordW-1:0]    point_x;
  logic signed [plap_pkg::CoordW-1:0]    point_y;
  logic [plap_pkg::LenW-1:0]             distance;
  modport source (output valid, op, point_x, point_y, distance, input ready);
  modport sink (input valid, op, point_x, point_y, distance, output ready);
endinterface

interface plap_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [plap_pkg::PosW-1:0]      pos_x;
  logic signed [plap_pkg::PosW-1:0]      pos_y;
  logic [16:0]                           total_length;
  logic [6:0]                            count_of_points;
  logic [1:0]                            status;
  modport source (output valid, pos_x, pos_y, total_length, count_of_points, status,
                  input ready);
  modport sink (input valid, pos_x, pos_y, total_length, count_of_points, status,
                output ready);
endinterface

// ===== src/plap_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module plap_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/polyline_arc_length_interpolator_unit.sv =====
// Clear, no-op and rejected requests go straight to the output stage; append first
// works out the segment length (the first point is stored at once); end-point queries
// read one entry; other queries scan one bound per cycle, then run a 50-step divide.
// Throughput: one request at a time; the next is taken once the result is in the
// output register, which may still wait for the sink.
// Reset: asynchronous, clears the point count and running length; the point RAM
// is not cleared, since only written entries are ever read.
module polyline_arc_length_interpolator_unit #(
  parameter int unsigned MaxPoints = plap_pkg::MaxPointsDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  plap_req_if.sink   req_i,
  plap_rsp_if.source rsp_o
);

  localparam int unsigned AddrW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned CntW = $clog2(MaxPoints + 1);
  localparam int unsigned LenW = plap_pkg::LenW;
  localparam int unsigned CW = plap_pkg::CoordW;
  localparam int unsigned PW = plap_pkg::PosW;
  localparam int unsigned EntW = $bits(plap_pkg::entry_t);

  plap_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [LenW-1:0]  running_q, running_d;
  logic [AddrW-1:0] k_q, k_d;
  logic [5:0]       step_q, step_d;

  logic signed [CW-1:0] px_q, px_d, py_q, py_d;
  logic [LenW-1:0]      dist_q, dist_d;

  logic signed [CW:0] dx_q, dx_d, dy_q, dy_d;
  logic [32:0]        sqx_q, sqx_d, sqy_q, sqy_d;
  logic [49:0]        rad_q, rad_d;
  logic [26:0]        rrem_q, rrem_d;
  logic [LenW-1:0]    root_q, root_d;

  plap_pkg::entry_t prev_q, prev_d;
  logic [LenW-1:0]  len_q, len_d;
  logic             negx_q, negx_d, negy_q, negy_d;
  logic [49:0]      dvx_q, dvx_d, dvy_q, dvy_d;
  logic [LenW:0]    remx_q, remx_d, remy_q, remy_d;

  logic [PW-1:0]    resx_q, resx_d, resy_q, resy_d;
  logic [1:0]       stat_q, stat_d;

  logic             ovalid_q, ovalid_d;
  logic [PW-1:0]    opx_q, opx_d, opy_q, opy_d;
  logic [16:0]      olen_q, olen_d;
  logic [6:0]       ocnt_q, ocnt_d;
  logic [1:0]       ost_q, ost_d;

  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  plap_pkg::entry_t wentry, rentry;
  logic [EntW-1:0]  rdata;

  plap_ram #(.Width(EntW), .Depth(MaxPoints)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wentry),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );
  assign rentry = plap_pkg::entry_t'(rdata);

  // Control and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= plap_pkg::S_IDLE;
      count_q   <= '0;
      running_q <= '0;
      ovalid_q  <= 1'b0;
      k_q       <= '0;
      step_q    <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      running_q <= running_d;
      ovalid_q  <= ovalid_d;
      k_q       <= k_d;
      step_q    <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= px_d;   py_q <= py_d;   dist_q <= dist_d;
    dx_q <= dx_d;   dy_q <= dy_d;   sqx_q <= sqx_d;   sqy_q <= sqy_d;
    rad_q <= rad_d; rrem_q <= rrem_d; root_q <= root_d;
    prev_q <= prev_d; len_q <= len_d; negx_q <= negx_d; negy_q <= negy_d;
    dvx_q <= dvx_d; dvy_q <= dvy_d; remx_q <= remx_d; remy_q <= remy_d;
    resx_q <= resx_d; resy_q <= resy_d; stat_q <= stat_d;
    opx_q <= opx_d; opy_q <= opy_d; olen_q <= olen_d; ocnt_q <= ocnt_d; ost_q <= ost_d;
  end

  // Next state, memory access and arithmetic steps.
  always_comb begin
    logic [26:0]       cand, trial;
    logic [LenW:0]     sum;
    logic [LenW:0]     rx, ry;
    logic [CW:0]       ax, ay;
    logic [CW:0]       bdx, bdy;
    logic [41:0]       prx, pry;
    logic [LenW:0]     qx, qy;
    logic [PW-1:0]     basex, basey;
    state_d = state_q;   count_d = count_q; running_d = running_q;
    k_d = k_q;           step_d = step_q;
    px_d = px_q; py_d = py_q; dist_d = dist_q;
    dx_d = dx_q; dy_d = dy_q; sqx_d = sqx_q; sqy_d = sqy_q;
    rad_d = rad_q; rrem_d = rrem_q; root_d = root_q;
    prev_d = prev_q; len_d = len_q; negx_d = negx_q; negy_d = negy_q;
    dvx_d = dvx_q; dvy_d = dvy_q; remx_d = remx_q; remy_d = remy_q;
    resx_d = resx_q; resy_d = resy_q; stat_d = stat_q;
    opx_d = opx_q; opy_d = opy_q; olen_d = olen_q; ocnt_d = ocnt_q; ost_d = ost_q;
    ovalid_d = ovalid_q & ~rsp_o.ready;
    we = 1'b0; waddr = '0; wentry = '0; raddr = '0;
    req_i.ready = (state_q == plap_pkg::S_IDLE);
    cand = '0; trial = '0; sum = '0; rx = '0; ry = '0; ax = '0; ay = '0;
    bdx = '0; bdy = '0; prx = '0; pry = '0; qx = '0; qy = '0; basex = '0; basey = '0;

    case (state_q)
      plap_pkg::S_IDLE: begin
        if (req_i.valid) begin
          px_d = req_i.point_x; py_d = req_i.point_y; dist_d = req_i.distance;
          resx_d = '0; resy_d = '0; stat_d = plap_pkg::ST_OK;
          state_d = plap_pkg::S_OUT;
          case (plap_pkg::op_e'(req_i.op))
            plap_pkg::OP_CLEAR: begin
              count_d = '0; running_d = '0;
            end
            plap_pkg::OP_APPEND: begin
              if (count_q >= CntW'(MaxPoints)) begin
                stat_d = plap_pkg::ST_FULL;
              end else if (count_q == '0) begin
                we = 1'b1; waddr = '0;
                wentry.x = req_i.point_x; wentry.y = req_i.point_y; wentry.bound = '0;
                count_d = CntW'(1);
              end else begin
                raddr = AddrW'(count_q - CntW'(1));
                state_d = plap_pkg::S_APP_RD;
              end
            end
            plap_pkg::OP_QUERY: begin
              if (count_q < CntW'(2)) begin
                stat_d = plap_pkg::ST_SHORT;
              end else if (req_i.distance == '0) begin
                raddr = '0;
                state_d = plap_pkg::S_QRY_END;
              end else begin
                raddr = AddrW'(count_q - CntW'(1));
                state_d = plap_pkg::S_QRY_TAIL;
              end
            end
            default: ;
          endcase
        end
      end
      // Append: difference to the previous point, squares, then the root.
      plap_pkg::S_APP_RD: begin
        dx_d = {px_q[CW-1], px_q} - {rentry.x[CW-1], rentry.x};
        dy_d = {py_q[CW-1], py_q} - {rentry.y[CW-1], rentry.y};
        state_d = plap_pkg::S_APP_SQ;
      end
      plap_pkg::S_APP_SQ: begin
        sqx_d = 33'(dx_q * dx_q);
        sqy_d = 33'(dy_q * dy_q);
        state_d = plap_pkg::S_APP_INIT;
      end
      plap_pkg::S_APP_INIT: begin
        rad_d = {({1'b0, sqx_q} + {1'b0, sqy_q}), 16'b0};
        rrem_d = '0; root_d = '0;
        step_d = 6'(plap_pkg::RootSteps - 1);
        state_d = plap_pkg::S_APP_ROOT;
      end
      plap_pkg::S_APP_ROOT: begin
        cand = {rrem_q[24:0], rad_q[49:48]};
        trial = {root_q, 2'b01};
        if (cand >= trial) begin
          rrem_d = cand - trial;
          root_d = {root_q[LenW-2:0], 1'b1};
        end else begin
          rrem_d = cand;
          root_d = {root_q[LenW-2:0], 1'b0};
        end
        rad_d = {rad_q[47:0], 2'b00};
        step_d = step_q - 6'd1;
        if (step_q == '0) state_d = plap_pkg::S_APP_WR;
      end
      plap_pkg::S_APP_WR: begin
        sum = {1'b0, running_q} + {1'b0, root_q};
        running_d = sum[LenW] ? plap_pkg::LenMax : sum[LenW-1:0];
        we = 1'b1; waddr = AddrW'(count_q);
        wentry.x = px_q; wentry.y = py_q; wentry.bound = running_d;
        count_d = count_q + CntW'(1);
        state_d = plap_pkg::S_OUT;
      end
      // Query: endpoint answers.
      plap_pkg::S_QRY_END: begin
        resx_d = {rentry.x, 8'b0}; resy_d = {rentry.y, 8'b0};
        state_d = plap_pkg::S_OUT;
      end
      plap_pkg::S_QRY_TAIL: begin
        if (dist_q >= rentry.bound) begin
          resx_d = {rentry.x, 8'b0}; resy_d = {rentry.y, 8'b0};
          state_d = plap_pkg::S_OUT;
        end else begin
          raddr = '0; k_d = '0;
          state_d = plap_pkg::S_QRY_CHK;
        end
      end
      // Scan bounds one per cycle until one covers the distance.
      plap_pkg::S_QRY_CHK: begin
        if (dist_q > rentry.bound) begin
          prev_d = rentry;
          k_d = k_q + AddrW'(1);
          raddr = k_q + AddrW'(1);
        end else begin
          ax = {prev_q.x[CW-1], prev_q.x}; ay = {prev_q.y[CW-1], prev_q.y};
          dx_d = {rentry.x[CW-1], rentry.x} - ax;
          dy_d = {rentry.y[CW-1], rentry.y} - ay;
          len_d = rentry.bound - prev_q.bound;
          dist_d = dist_q - prev_q.bound;
          state_d = plap_pkg::S_QRY_MUL;
        end
      end
      plap_pkg::S_QRY_MUL: begin
        negx_d = dx_q[CW]; negy_d = dy_q[CW];
        bdx = dx_q[CW] ? -dx_q : dx_q;
        bdy = dy_q[CW] ? -dy_q : dy_q;
        prx = bdx * dist_q;
        pry = bdy * dist_q;
        dvx_d = {prx, 8'b0}; dvy_d = {pry, 8'b0};
        remx_d = '0; remy_d = '0;
        step_d = 6'(plap_pkg::DivSteps - 1);
        state_d = plap_pkg::S_QRY_DIV;
      end
      // Restoring division, one quotient bit per cycle on both axes.
      plap_pkg::S_QRY_DIV: begin
        rx = {remx_q[LenW-1:0], dvx_q[49]};
        ry = {remy_q[LenW-1:0], dvy_q[49]};
        if (rx >= {1'b0, len_q}) begin
          remx_d = rx - {1'b0, len_q}; dvx_d = {dvx_q[48:0], 1'b1};
        end else begin
          remx_d = rx; dvx_d = {dvx_q[48:0], 1'b0};
        end
        if (ry >= {1'b0, len_q}) begin
          remy_d = ry - {1'b0, len_q}; dvy_d = {dvy_q[48:0], 1'b1};
        end else begin
          remy_d = ry; dvy_d = {dvy_q[48:0], 1'b0};
        end
        step_d = step_q - 6'd1;
        if (step_q == '0) state_d = plap_pkg::S_QRY_FIN;
      end
      plap_pkg::S_QRY_FIN: begin
        basex = {prev_q.x, 8'b0}; basey = {prev_q.y, 8'b0};
        qx = dvx_q[LenW:0] + {{LenW{1'b0}}, (negx_q && remx_q != '0)};
        qy = dvy_q[LenW:0] + {{LenW{1'b0}}, (negy_q && remy_q != '0)};
        if (len_q == '0) begin
          resx_d = basex; resy_d = basey;
        end else begin
          resx_d = negx_q ? basex - qx[PW-1:0] : basex + qx[PW-1:0];
          resy_d = negy_q ? basey - qy[PW-1:0] : basey + qy[PW-1:0];
        end
        state_d = plap_pkg::S_OUT;
      end
      // Hand the result to the output register once it is free.
      plap_pkg::S_OUT: begin
        if (!ovalid_q || rsp_o.ready) begin
          ovalid_d = 1'b1;
          opx_d = resx_q; opy_d = resy_q;
          olen_d = running_q[LenW-1:8];
          ocnt_d = 7'(count_q);
          ost_d = stat_q;
          state_d = plap_pkg::S_IDLE;
        end
      end
      default: state_d = plap_pkg::S_IDLE;
    endcase
  end

  assign rsp_o.valid = ovalid_q;
  assign rsp_o.pos_x = opx_q;
  assign rsp_o.pos_y = opy_q;
  assign rsp_o.total_length = olen_q;
  assign rsp_o.count_of_points = ocnt_q;
  assign rsp_o.status = ost_q;

`ifndef ASSERT_OFF
  // The point count never exceeds the store depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxPoints)) else $error("point count above depth");

  // A path with fewer than two points has no length.
  a_len_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q < CntW'(2)) |-> (running_q == '0)) else $error("length without segment");

  // The bound scan stays within the stored points.
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == plap_pkg::S_QRY_CHK) |-> ({1'b0, k_q} < (CntW+1)'(count_q)))
    else $error("bound scan past last point");

  // A request is taken only once until its work is done.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready) else $error("second request taken");
`endif

endmodule

// ===== tb/tb_polyline_arc_length_interpolator_unit.sv =====
// Testbench for the polyline arc-length interpolator with a scoreboard and predictor.
`timescale 1ns / 100ps

module tb_polyline_arc_length_interpolator_unit;

  localparam int unsigned MaxPts = plap_pkg::MaxPointsDef;
  localparam int unsigned NumRandom = 856;

  // Expected response fields.
  typedef struct packed {
    logic signed [plap_pkg::PosW-1:0] pos_x;
    logic signed [plap_pkg::PosW-1:0] pos_y;
    logic [16:0]                      total_length;
    logic [6:0]                       count_of_points;
    logic [1:0]                       status;
  } resp_t;

  // Path predictor plus queue of expected responses.
  class path_scoreboard;
    int signed   px_q[MaxPts];
    int signed   py_q[MaxPts];
    longint      bound_q[MaxPts];
    int unsigned npts;
    longint      run_len;
    resp_t       pending[$];
    int          errors;

    function new();
      npts = 0;
      run_len = 0;
      errors = 0;
    endfunction

    function longint int_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned b;
      root = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= root + b) begin
          n -= root + b;
          root = (root >> 1) + b;
        end else begin
          root >>= 1;
        end
        b >>= 2;
      end
      return longint'(root);
    endfunction

    function longint blend(longint a, longint b, longint off, longint span);
      longint num;
      longint q;
      num = (b - a) * 256 * off;
      if (span == 0) return a * 256;
      if (num >= 0) q = num / span;
      else q = -((-num + span - 1) / span);
      return a * 256 + q;
    endfunction

    // Note an accepted request and queue its expected response.
    function void note_request(plap_pkg::op_e op, logic signed [15:0] x,
                               logic signed [15:0] y, logic [plap_pkg::LenW-1:0] qdist);
      resp_t r;
      longint rx, ry, dx, dy, seg, off, span;
      int unsigned s;
      r = '0;
      rx = 0;
      ry = 0;
      case (op)
        plap_pkg::OP_CLEAR: begin
          npts = 0;
          run_len = 0;
        end
        plap_pkg::OP_APPEND: begin
          if (npts >= MaxPts) begin
            r.status = plap_pkg::ST_FULL;
          end else begin
            if (npts > 0) begin
              dx = longint'(x) - px_q[npts-1];
              dy = longint'(y) - py_q[npts-1];
              seg = int_sqrt((dx * dx + dy * dy) << 16);
              run_len = run_len + seg;
              if (run_len > longint'(plap_pkg::LenMax)) run_len = longint'(plap_pkg::LenMax);
            end
            px_q[npts] = x;
            py_q[npts] = y;
            bound_q[npts] = (npts == 0) ? 0 : run_len;
            npts++;
          end
        end
        plap_pkg::OP_QUERY: begin
          if (npts < 2) begin
            r.status = plap_pkg::ST_SHORT;
          end else if (qdist == 0) begin
            rx = px_q[0] * 256;
            ry = py_q[0] * 256;
          end else if (longint'(qdist) >= bound_q[npts-1]) begin
            rx = px_q[npts-1] * 256;
            ry = py_q[npts-1] * 256;
          end else begin
            s = 0;
            while (s < npts - 1 && longint'(qdist) > bound_q[s]) s++;
            s = (s == 0) ? 0 : s - 1;
            off = longint'(qdist) - bound_q[s];
            span = bound_q[s+1] - bound_q[s];
            rx = blend(px_q[s], px_q[s+1], off, span);
            ry = blend(py_q[s], py_q[s+1], off, span);
          end
        end
        default: ;
      endcase
      r.pos_x = rx[plap_pkg::PosW-1:0];
      r.pos_y = ry[plap_pkg::PosW-1:0];
      r.total_length = run_len[24:8];
      r.count_of_points = npts[6:0];
      pending = {pending, r};
    endfunction

    // Compare one accepted response against the oldest expectation.
    function void check_response(resp_t got);
      resp_t exp_r;
      if (pending.size() == 0) begin
        $error("response with nothing expected");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.pos_x !== exp_r.pos_x) begin
        $error("pos_x expected %0h got %0h", exp_r.pos_x, got.pos_x);
        errors++;
      end
      if (got.pos_y !== exp_r.pos_y) begin
        $error("pos_y expected %0h got %0h", exp_r.pos_y, got.pos_y);
        errors++;
      end
      if (got.total_length !== exp_r.total_length) begin
        $error("total_length expected %0d got %0d", exp_r.total_length, got.total_length);
        errors++;
      end
      if (got.count_of_points !== exp_r.count_of_points) begin
        $error("count_of_points expected %0d got %0d", exp_r.count_of_points,
               got.count_of_points);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $error("status expected %0d got %0d", exp_r.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   hold_sink;
  path_scoreboard sb;

  plap_req_if req_if ();
  plap_rsp_if rsp_if ();

  polyline_arc_length_interpolator_unit #(.MaxPoints(MaxPts)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  // Clock.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Gap length: mostly short, sometimes long.
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(3);
    return $urandom_range(150, 20);
  endfunction

  // Send one request and wait for its acceptance.
  task automatic send(plap_pkg::op_e op, logic signed [15:0] x, logic signed [15:0] y,
                      logic [plap_pkg::LenW-1:0] qdist);
    req_if.valid <= 1'b1;
    req_if.op <= op;
    req_if.point_x <= x;
    req_if.point_y <= y;
    req_if.distance <= qdist;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    sb.note_request(op, x, y, qdist);
  endtask

  task automatic idle_sender(int unsigned n);
    if (n > 0) begin
      req_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // Query distance: mostly inside the path, sometimes at its edges or beyond.
  function automatic logic [plap_pkg::LenW-1:0] pick_distance();
    int unsigned p;
    longint top;
    top = sb.run_len;
    p = $urandom_range(99);
    if (p < 5) return '0;
    if (p < 10) return top[plap_pkg::LenW-1:0];
    if (p < 15) return plap_pkg::LenW'($urandom);
    if (p < 20 && sb.npts > 1)
      return sb.bound_q[$urandom_range(sb.npts - 1)][plap_pkg::LenW-1:0];
    return plap_pkg::LenW'($urandom_range(top + 2));
  endfunction

  // Point near the last one most of the time, anywhere otherwise.
  function automatic logic [15:0] pick_coord(bit is_x);
    int signed base;
    int signed v;
    if (sb.npts == 0 || $urandom_range(9) < 2) return 16'($urandom);
    base = is_x ? sb.px_q[sb.npts-1] : sb.py_q[sb.npts-1];
    v = base + $signed($urandom_range(400)) - 200;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Response side: accept with random stalls, checking every response.
  initial begin
    resp_t got;
    int unsigned w;
    bit held;
    held = 1'b0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        got.pos_x = rsp_if.pos_x;
        got.pos_y = rsp_if.pos_y;
        got.total_length = rsp_if.total_length;
        got.count_of_points = rsp_if.count_of_points;
        got.status = rsp_if.status;
        sb.check_response(got);
      end
      if (hold_sink && !held) begin
        rsp_if.ready <= 1'b0;
        repeat (600) @(posedge clk_i);
        held = 1'b1;
        rsp_if.ready <= 1'b1;
      end else if (rsp_if.ready && $urandom_range(9) < 2) begin
        w = gap_len();
        if (w > 0) begin
          rsp_if.ready <= 1'b0;
          repeat (w) @(posedge clk_i);
        end
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Request side: directed part, then a random mix of requests.
  initial begin
    plap_pkg::op_e op;
    int unsigned p;
    sb = new();
    hold_sink = 1'b0;
    req_if.valid = 1'b0;
    req_if.op = plap_pkg::OP_NOP;
    req_if.point_x = '0;
    req_if.point_y = '0;
    req_if.distance = '0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short path and no-op.
    send(plap_pkg::OP_QUERY, '0, '0, 25'd100);
    send(plap_pkg::OP_APPEND, 16'sh8000, 16'sh8000, '0);
    send(plap_pkg::OP_QUERY, '0, '0, '0);
    send(plap_pkg::OP_NOP, 16'sh7fff, 16'sh7fff, plap_pkg::LenMax);
    // Extreme diagonal, then a zero-length segment.
    send(plap_pkg::OP_APPEND, 16'sh7fff, 16'sh7fff, '0);
    send(plap_pkg::OP_APPEND, 16'sh7fff, 16'sh7fff, '0);
    send(plap_pkg::OP_QUERY, '0, '0, '0);
    send(plap_pkg::OP_QUERY, '0, '0, 25'd1);
    send(plap_pkg::OP_QUERY, '0, '0, 25'd12345678);
    send(plap_pkg::OP_QUERY, '0, '0, plap_pkg::LenMax);
    // Saturation of the running length.
    for (int i = 0; i < 4; i++) begin
      send(plap_pkg::OP_APPEND, 16'sh8000, 16'sh8000, '0);
      send(plap_pkg::OP_APPEND, 16'sh7fff, 16'sh7fff, '0);
    end
    send(plap_pkg::OP_QUERY, '0, '0, plap_pkg::LenMax);
    send(plap_pkg::OP_CLEAR, '0, '0, '0);
    // Fill the store and drop one more.
    for (int i = 0; i <= MaxPts; i++)
      send(plap_pkg::OP_APPEND, 16'(i * 3), 16'(-i * 5), '0);
    send(plap_pkg::OP_QUERY, '0, '0, 25'd300);
    send(plap_pkg::OP_CLEAR, '0, '0, '0);

    // Back pressure: hold the sink while offering more requests.
    hold_sink = 1'b1;
    for (int i = 0; i < 6; i++)
      send(plap_pkg::OP_APPEND, 16'($urandom), 16'($urandom), '0);
    drain();
    send(plap_pkg::OP_CLEAR, '0, '0, '0);

    // Random part.
    for (int n = 0; n < NumRandom; n++) begin
      p = $urandom_range(99);
      if (p < 3) op = plap_pkg::OP_CLEAR;
      else if (p < 5) op = plap_pkg::OP_NOP;
      else if (p < 45 && sb.npts < MaxPts + 2) op = plap_pkg::OP_APPEND;
      else op = plap_pkg::OP_QUERY;
      if (sb.npts >= MaxPts && $urandom_range(3) == 0) op = plap_pkg::OP_CLEAR;
      send(op, pick_coord(1'b1), pick_coord(1'b0), pick_distance());
      if (n == NumRandom / 2) drain();
      if ($urandom_range(4) == 0) idle_sender(gap_len());
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
src/plap_pkg.sv
src/plap_if.sv
src/plap_ram.sv
src/polyline_arc_length_interpolator_unit.sv
tb/tb_polyline_arc_length_interpolator_unit.sv
